// ===== rtl/min_partition_difference_top_macros.svh =====
// ----------------------------------------------------------------------------
// Min partition difference assertion macros
// Concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef MIN_PARTITION_DIFFERENCE_TOP_MACROS_SVH
`define MIN_PARTITION_DIFFERENCE_TOP_MACROS_SVH

// same-cycle implication
`define MPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Min partition difference package
// Word types, map geometry and map access request.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int MAX_SUM   = 4095;
    localparam int MAX_VALUE = 255;
    localparam int WORD_W    = 64;
    localparam int MAP_WORDS = (MAX_SUM + WORD_W) / WORD_W;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int SUM_W     = 12;
    localparam int VAL_W     = 8;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SHIFT_W   = $clog2(WORD_W) + 1;
    localparam int BIT_W     = $clog2(WORD_W);

    typedef struct packed {
        logic [VAL_W-1:0] element_value;
        logic             last_element;
    } t_in;

    typedef struct packed {
        logic [SUM_W-1:0] min_difference;
        logic             overflow;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              clear;
    } t_map_req;

endpackage

// ===== rtl/mpd_map.sv =====
// ----------------------------------------------------------------------------
// Reachable-sum map
// Word memory with two registered read ports, one write port and per-word
// valid bits; since the last clear an unwritten word reads as 0, word 0 as 1.
// ----------------------------------------------------------------------------
module mpd_map
    import mpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_req          i_req,
    output logic [WORD_W-1:0] o_rd_a,
    output logic [WORD_W-1:0] o_rd_b
);

    logic [WORD_W-1:0]    mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_valid;
    logic [WORD_W-1:0]    r_rd_a;
    logic [WORD_W-1:0]    r_rd_b;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_za;
    logic                 r_zb;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= mem[i_req.raddr_a];
        r_rd_b <= mem[i_req.raddr_b];
        r_va   <= r_valid[i_req.raddr_a];
        r_vb   <= r_valid[i_req.raddr_b];
        r_za   <= (i_req.raddr_a == '0);
        r_zb   <= (i_req.raddr_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rd_a = r_va ? r_rd_a : {{(WORD_W-1){1'b0}}, r_za};
    assign o_rd_b = r_vb ? r_rd_b : {{(WORD_W-1){1'b0}}, r_zb};

endmodule

// ===== rtl/min_partition_difference_top.sv =====
// ----------------------------------------------------------------------------
// Min partition difference top
// Element with nonzero value: read-modify-write sweep of the 64-word map at
// one word per cycle, then the next accept; zero value: no sweep. Last
// element: after the sweep, or the accept for a zero value, map words are
// scanned down from the one holding total/2, then that word's 8 bytes from
// the top; an overflowed set posts without a scan. A result waits while the
// previous word is held. Reset and each result clear the map at once through
// per-word valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module min_partition_difference_top
    import mpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_POST,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_BYTE,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_q;
    logic [BIT_W-1:0]  r_r;
    logic              r_last;
    logic [SUM_W-1:0]  r_total;
    logic              r_ovf;
    logic              r_iss;
    logic              r_dv;
    logic              r_b_ok;
    logic [ADDR_W-1:0] r_wa;
    logic [WORD_W-1:0] r_prev;
    logic [ADDR_W-1:0] r_sw;
    logic              r_first;
    logic [WORD_W-1:0] r_word;
    logic [2:0]        r_byte;
    logic [SUM_W-1:0]  r_diff;
    logic              r_dovf;
    logic              r_o_valid;
    t_out              r_o_data;

    t_map_req          map_req;
    logic [WORD_W-1:0] rd_a;
    logic [WORD_W-1:0] rd_b;
    logic [WORD_W-1:0] eff_b;
    logic [WORD_W-1:0] add_word;
    logic [CNT_W-1:0]  b_idx;
    logic              b_ok;
    logic [WORD_W-1:0] scan_mask;
    logic [WORD_W-1:0] scan_word;
    logic [7:0]        cur_byte;
    logic [SUM_W-1:0]  s_val;
    logic [SUM_W:0]    n_sum;
    logic              accept;
    logic              emit_fire;

    function automatic logic [2:0] top_bit8(input logic [7:0] b);
        logic [2:0] idx;
        idx = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign emit_fire = (r_state == ST_EMIT) && (!r_o_valid || i_ready);
    assign n_sum     = {1'b0, r_total} + (SUM_W+1)'(i_data.element_value);

    assign b_idx = r_cnt - CNT_W'(r_q) - CNT_W'(1);
    assign b_ok  = (r_cnt > CNT_W'(r_q));

    assign eff_b    = r_b_ok ? rd_b : '0;
    assign add_word = (r_prev << r_r) | (eff_b >> (SHIFT_W'(WORD_W) - SHIFT_W'(r_r)));

    assign scan_mask = r_first ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - r_total[BIT_W:1]))
                               : {WORD_W{1'b1}};
    assign scan_word = rd_a & scan_mask;
    assign cur_byte  = r_word[r_byte*8 +: 8];
    assign s_val     = SUM_W'({r_sw, r_byte, top_bit8(cur_byte)});

    always_comb begin
        map_req.we      = r_dv;
        map_req.waddr   = r_wa;
        map_req.wdata   = rd_a | add_word;
        map_req.raddr_a = (r_state == ST_SWEEP) ? r_cnt[ADDR_W-1:0] : r_sw;
        map_req.raddr_b = b_idx[ADDR_W-1:0];
        map_req.clear   = emit_fire;
    end

    mpd_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_iss     <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_iss  <= (r_state == ST_SWEEP);
            r_dv   <= (r_state == ST_SWEEP) && (r_cnt != CNT_W'(MAP_WORDS));
            r_b_ok <= b_ok;
            r_wa   <= r_cnt[ADDR_W-1:0];
            if (r_iss) begin
                r_prev <= eff_b;
            end
            if (emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_q    <= i_data.element_value[VAL_W-1:BIT_W];
                        r_r    <= i_data.element_value[BIT_W-1:0];
                        r_last <= i_data.last_element;
                        r_cnt  <= CNT_W'(MAP_WORDS);
                        if (n_sum > (SUM_W+1)'(MAX_SUM)) begin
                            r_total <= SUM_W'(MAX_SUM);
                            r_ovf   <= 1'b1;
                        end else begin
                            r_total <= n_sum[SUM_W-1:0];
                        end
                        if (i_data.element_value != '0) begin
                            r_state <= ST_SWEEP;
                        end else if (i_data.last_element) begin
                            r_state <= ST_POST;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= r_last ? ST_POST : ST_IDLE;
                end
                ST_POST: begin
                    r_sw    <= ADDR_W'(r_total[SUM_W-1:BIT_W+1]);
                    r_first <= 1'b1;
                    r_diff  <= '0;
                    r_dovf  <= r_ovf;
                    r_state <= r_ovf ? ST_EMIT : ST_SCAN_RD;
                end
                ST_SCAN_RD: begin
                    r_state <= ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (scan_word != '0) begin
                        r_word  <= scan_word;
                        r_byte  <= 3'd7;
                        r_state <= ST_BYTE;
                    end else begin
                        r_sw    <= r_sw - ADDR_W'(1);
                        r_first <= 1'b0;
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_BYTE: begin
                    if (cur_byte != '0) begin
                        r_diff  <= r_total - {s_val[SUM_W-2:0], 1'b0};
                        r_state <= ST_EMIT;
                    end else begin
                        r_byte <= r_byte - 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        r_o_data.min_difference  <= r_diff;
                        r_o_data.overflow        <= r_dovf;
                        r_total                  <= '0;
                        r_ovf                    <= 1'b0;
                        r_state                  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== rtl/mpd_checker.sv =====
// ----------------------------------------------------------------------------
// Min partition difference port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "min_partition_difference_top_macros.svh"

module mpd_checker
    import mpd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_in  i_data,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    `MPD_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_valid && o_data.overflow, o_data.min_difference == '0, "overflow result carries nonzero difference")
    `MPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "stalled result word changed")
    `MPD_ASSERT_NEXT(a_sweep_busy, i_clk, i_rst_n, i_valid && o_ready && (i_data.element_value != '0), !o_ready, "nonzero element did not start a map sweep")
    `MPD_ASSERT_NEXT(a_zero_pass, i_clk, i_rst_n, i_valid && o_ready && (i_data.element_value == '0) && !i_data.last_element, o_ready, "zero element stalled the input")

endmodule

bind min_partition_difference_top mpd_checker u_mpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== sim/min_partition_difference_top_test.sv =====
// ----------------------------------------------------------------------------
// Min partition difference top testbench
// Feeds sets of elements to the block, one word per element. A scoreboard
// tracks reachable subset sums and the set total to predict each result word.
// Covers directed corner sets, random sets of many shapes, both sides idling,
// and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module min_partition_difference_top_test;
    import mpd_pkg::*;

    localparam int     ITEMS        = 1850;
    localparam int     HOLD_CYCLES  = 1000;
    localparam int     DRAIN_CYCLES = 200;
    localparam longint LIMIT_TIME   = 64'd20_000_000;

    class partition_scoreboard;
        logic [MAX_SUM:0] reach_map;
        int unsigned      set_total;
        bit               set_overflow;
        t_out             diff_queue[$];
        int               sets_in;
        int               overflow_sets;
        int               results_out;
        int               errors;

        function new();
            clear_set();
            sets_in       = 0;
            overflow_sets = 0;
            results_out   = 0;
            errors        = 0;
        endfunction

        function void clear_set();
            reach_map    = '0;
            reach_map[0] = 1'b1;
            set_total    = 0;
            set_overflow = 1'b0;
        endfunction

        function void note_word(t_in w);
            int unsigned v;
            int unsigned half;
            t_out        want;
            v = w.element_value;
            if (v > MAX_VALUE) begin
                v = MAX_VALUE;
            end
            if (set_total + v > MAX_SUM) begin
                set_overflow = 1'b1;
                set_total    = MAX_SUM;
            end else begin
                set_total += v;
            end
            reach_map = reach_map | (reach_map << v);
            if (!w.last_element) begin
                return;
            end
            if (set_overflow) begin
                want.min_difference = '0;
                want.overflow       = 1'b1;
                overflow_sets++;
            end else begin
                half = set_total / 2;
                while (half > 0 && !reach_map[half]) begin
                    half--;
                end
                want.min_difference = SUM_W'(set_total - 2 * half);
                want.overflow       = 1'b0;
            end
            diff_queue.push_back(want);
            sets_in++;
            clear_set();
        endfunction

        function void check_word(t_out got);
            t_out want;
            results_out++;
            if (diff_queue.size() == 0) begin
                $error("unexpected result word: min_difference %0d overflow %0d",
                       got.min_difference, got.overflow);
                errors++;
                return;
            end
            want = diff_queue.pop_front();
            if (got.min_difference !== want.min_difference) begin
                $error("min_difference: expected %0d, actual %0d",
                       want.min_difference, got.min_difference);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    partition_scoreboard sb = new();
    logic [VAL_W-1:0]    set_vals[$];
    int                  words_sent = 0;
    bit                  hold_done  = 1'b0;

    min_partition_difference_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("min_partition_difference_top verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_word(i_data);
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_word(o_data);
        end
    end

    initial begin
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.results_out >= 40) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (sb.results_out >= 120 && sb.results_out < 180) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 12);
            end
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            return '0;
        end else if (r < 45) begin
            return VAL_W'($urandom_range(15));
        end else if (r < 60) begin
            return VAL_W'($urandom_range(255, 128));
        end
        return VAL_W'($urandom_range(255));
    endfunction

    task automatic send_word(input t_in w);
        int gap;
        if (!(words_sent >= 700 && words_sent < 1100) && $urandom_range(99) < 12) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_set();
        t_in w;
        for (int k = 0; k < set_vals.size(); k++) begin
            w.element_value = set_vals[k];
            w.last_element  = (k == set_vals.size() - 1);
            send_word(w);
        end
    endtask

    initial begin
        int r;
        int len;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_vals = '{8'd0};
        send_set();
        set_vals = '{8'd255};
        send_set();
        set_vals = '{8'd5, 8'd0, 8'd7};
        send_set();
        set_vals = '{8'd128, 8'd127};
        send_set();
        set_vals.delete();
        repeat (17) set_vals.push_back(8'd255);
        send_set();

        while (words_sent < ITEMS) begin
            r = $urandom_range(99);
            set_vals.delete();
            if (r < 60) begin
                len = $urandom_range(1, 6);
                repeat (len) set_vals.push_back(pick_value());
            end else if (r < 75) begin
                len = $urandom_range(7, 12);
                repeat (len) set_vals.push_back(pick_value());
            end else if (r < 85) begin
                set_vals.push_back(VAL_W'($urandom_range(255)));
            end else if (r < 93) begin
                len = $urandom_range(15, 20);
                repeat (len) set_vals.push_back(VAL_W'($urandom_range(255, 192)));
            end else begin
                repeat (16) set_vals.push_back(8'd255);
                set_vals.push_back(VAL_W'($urandom_range(16, 14)));
            end
            send_set();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.diff_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.diff_queue.size() != 0) begin
            $error("%0d result words never arrived", sb.diff_queue.size());
            sb.errors++;
        end
        $display("Sent %0d element words in %0d sets, %0d of them past the sum limit.",
                 words_sent, sb.sets_in, sb.overflow_sets);
        $display("Checked %0d result words, with a %0d-cycle output hold-off.",
                 sb.results_out, HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("min_partition_difference_top verification clean");
        end else begin
            $display("min_partition_difference_top verification failed");
        end
        $finish;
    end

endmodule
